>>> rtl/core/dpbt_pkg.sv
// shared types and constants for the dibit pulse bus transmitter
`timescale 1ns / 1ps
`default_nettype none
package dpbt_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 8;
  // the byte index field addresses at most this many entries
  localparam int INDEX_SPAN = 8;
  localparam int POS_W = 4;
  localparam int CNT_W = 9;

  localparam logic [3:0] FRAME_LENGTH_RST = 4'd5;
  localparam logic [3:0] MAX_ATTEMPTS_RST = 4'd5;
  localparam logic [7:0] IDLE_GAP_RST = 8'd20;
  localparam logic [7:0] BACKOFF_BASE_RST = 8'h80;
  localparam logic [3:0] ATTEMPT_SAT = 4'd15;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2
  } command_t;

  typedef enum logic [1:0] {
    REG_FRAME_LENGTH = 2'd0,
    REG_MAX_ATTEMPTS = 2'd1,
    REG_IDLE_GAP     = 2'd2,
    REG_BACKOFF_BASE = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_GAP     = 3'd1,
    PH_DRIVE   = 3'd2,
    PH_RELEASE = 3'd3,
    PH_BACKOFF = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_SENDING = 3'd1,
    ST_BACKOFF = 3'd2,
    ST_SENT    = 3'd3,
    ST_FAILED  = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] byte_index;
    logic [7:0] byte_value;
    logic       rx_released;
    logic [5:0] backoff_random;
  } item_t;

  typedef struct packed {
    logic       line_drive;
    logic [2:0] status;
    logic [3:0] attempts_used;
  } result_t;

  typedef struct packed {
    logic [3:0] frame_length;
    logic [3:0] max_attempts;
    logic [7:0] idle_gap_bits;
    logic [7:0] backoff_base;
  } cfg_t;

  typedef struct packed {
    logic       en;
    logic [2:0] addr;
    logic [7:0] data;
  } store_wr_t;

endpackage
`default_nettype wire

>>> rtl/core/dpbt_frame_store.sv
// frame byte store: register file with one write port and one read port
`timescale 1ns / 1ps
`default_nettype none
module dpbt_frame_store #(
  parameter int MAX_FRAME_BYTES = dpbt_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic                      clk,
  input  wire dpbt_pkg::store_wr_t       wr,
  input  wire logic [dpbt_pkg::POS_W-1:0] rd_pos,
  output logic [7:0]                     rd_data
);
  import dpbt_pkg::*;

  localparam int DEPTH = (MAX_FRAME_BYTES < INDEX_SPAN) ? MAX_FRAME_BYTES : INDEX_SPAN;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] entries [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en && ({1'b0, wr.addr} < POS_W'(DEPTH))) begin
      entries[wr.addr[IDX_W-1:0]] <= wr.data;
    end
  end

  always_comb begin
    if (rd_pos < POS_W'(DEPTH)) begin
      rd_data = entries[rd_pos[IDX_W-1:0]];
    end else begin
      rd_data = 8'd0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/dpbt_ctrl.sv
// transmit sequencer: gap, drive, release and backoff phases with result forming
`timescale 1ns / 1ps
`default_nettype none
module dpbt_ctrl #(
  parameter int MAX_FRAME_BYTES = dpbt_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       fire,
  input  wire dpbt_pkg::item_t            item,
  input  wire dpbt_pkg::cfg_t             cfg,
  input  wire logic [7:0]                 rd_data,
  output dpbt_pkg::store_wr_t             store_wr,
  output logic [dpbt_pkg::POS_W-1:0]      rd_pos,
  output dpbt_pkg::result_t               result
);
  import dpbt_pkg::*;

  localparam int LIM = (MAX_FRAME_BYTES < INDEX_SPAN) ? MAX_FRAME_BYTES : INDEX_SPAN;

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] period_counter, period_counter_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [1:0]       dibit_position, dibit_position_next;
  logic [1:0]       current_dibit, current_dibit_next;
  logic             fault_seen, fault_seen_next;
  logic             echo_seen, echo_seen_next;
  logic [3:0]       attempt_count, attempt_count_next;
  status_t          last_outcome, last_outcome_next;

  logic [CNT_W-1:0] gap_len, backoff_len, cnt_dec;
  logic [3:0]       att_inc, max_eff, end_att;
  logic [POS_W-1:0] frame_eff, bpos_inc;
  logic [1:0]       dpos_inc, rd_dibit_pos, rd_dibit;
  logic             fault_now, echo_now;
  logic             start_dibit, do_fail, end_bo;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      period_counter <= '0;
      byte_position  <= '0;
      dibit_position <= '0;
      current_dibit  <= '0;
      fault_seen     <= 1'b0;
      echo_seen      <= 1'b0;
      attempt_count  <= '0;
      last_outcome   <= ST_IDLE;
    end else begin
      phase          <= phase_next;
      period_counter <= period_counter_next;
      byte_position  <= byte_position_next;
      dibit_position <= dibit_position_next;
      current_dibit  <= current_dibit_next;
      fault_seen     <= fault_seen_next;
      echo_seen      <= echo_seen_next;
      attempt_count  <= attempt_count_next;
      last_outcome   <= last_outcome_next;
    end
  end

  always_comb begin
    store_wr.en   = fire && (item.command == CMD_LOAD);
    store_wr.addr = item.byte_index;
    store_wr.data = item.byte_value;
  end

  // helper values
  always_comb begin
    gap_len     = (cfg.idle_gap_bits == 8'd0) ? CNT_W'(1) : CNT_W'(cfg.idle_gap_bits);
    backoff_len = CNT_W'(cfg.backoff_base) + CNT_W'(item.backoff_random);
    cnt_dec     = period_counter - CNT_W'(1);
    att_inc     = (attempt_count == ATTEMPT_SAT) ? attempt_count : attempt_count + 4'd1;
    max_eff     = (cfg.max_attempts == 4'd0) ? 4'd1 : cfg.max_attempts;
    if (cfg.frame_length == 4'd0) begin
      frame_eff = POS_W'(1);
    end else if (POS_W'(cfg.frame_length) > POS_W'(LIM)) begin
      frame_eff = POS_W'(LIM);
    end else begin
      frame_eff = POS_W'(cfg.frame_length);
    end
    fault_now = fault_seen | ~item.rx_released;
    echo_now  = echo_seen | ~item.rx_released;
    dpos_inc  = dibit_position + 2'd1;
    bpos_inc  = (dibit_position == 2'd3) ? byte_position + POS_W'(1) : byte_position;
    // after the gap the frame restarts at the first dibit of byte zero
    rd_pos       = (phase == PH_GAP) ? '0 : bpos_inc;
    rd_dibit_pos = (phase == PH_GAP) ? 2'd0 : dpos_inc;
    case (rd_dibit_pos)
      2'd0:    rd_dibit = rd_data[7:6];
      2'd1:    rd_dibit = rd_data[5:4];
      2'd2:    rd_dibit = rd_data[3:2];
      default: rd_dibit = rd_data[1:0];
    endcase
  end

  // next state
  always_comb begin
    phase_next          = phase;
    period_counter_next = period_counter;
    byte_position_next  = byte_position;
    dibit_position_next = dibit_position;
    current_dibit_next  = current_dibit;
    fault_seen_next     = fault_seen;
    echo_seen_next      = echo_seen;
    attempt_count_next  = attempt_count;
    last_outcome_next   = last_outcome;
    start_dibit         = 1'b0;
    do_fail             = 1'b0;
    end_bo              = 1'b0;
    end_att             = attempt_count;

    if (fire && (item.command == CMD_START) && (phase == PH_IDLE)) begin
      attempt_count_next  = '0;
      phase_next          = PH_GAP;
      period_counter_next = gap_len;
      fault_seen_next     = 1'b0;
    end else if (fire && (item.command == CMD_TICK)) begin
      case (phase)
        PH_GAP: begin
          fault_seen_next     = fault_now;
          period_counter_next = cnt_dec;
          if (cnt_dec == '0) begin
            if (fault_now) begin
              do_fail = 1'b1;
            end else begin
              byte_position_next  = '0;
              dibit_position_next = 2'd0;
              start_dibit         = 1'b1;
            end
          end
        end
        PH_DRIVE: begin
          echo_seen_next      = echo_now;
          period_counter_next = cnt_dec;
          if (cnt_dec == '0) begin
            if (!echo_now) begin
              do_fail = 1'b1;
            end else begin
              phase_next          = PH_RELEASE;
              period_counter_next = CNT_W'(current_dibit) + CNT_W'(1);
              fault_seen_next     = 1'b0;
            end
          end
        end
        PH_RELEASE: begin
          fault_seen_next     = fault_now;
          period_counter_next = cnt_dec;
          if (cnt_dec == '0) begin
            if (fault_now) begin
              do_fail = 1'b1;
            end else begin
              dibit_position_next = dpos_inc;
              byte_position_next  = bpos_inc;
              if (bpos_inc >= frame_eff) begin
                phase_next        = PH_IDLE;
                last_outcome_next = ST_SENT;
              end else begin
                start_dibit = 1'b1;
              end
            end
          end
        end
        PH_BACKOFF: begin
          period_counter_next = cnt_dec;
          if (cnt_dec == '0) begin
            end_bo = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (start_dibit) begin
      current_dibit_next  = rd_dibit;
      phase_next          = PH_DRIVE;
      period_counter_next = CNT_W'(3'd4 - {1'b0, rd_dibit});
      echo_seen_next      = 1'b0;
    end

    if (do_fail) begin
      attempt_count_next  = att_inc;
      phase_next          = PH_BACKOFF;
      period_counter_next = backoff_len;
      // zero backoff decides retry or failure at once
      if (backoff_len == '0) begin
        end_bo  = 1'b1;
        end_att = att_inc;
      end
    end

    if (end_bo) begin
      if (end_att >= max_eff) begin
        phase_next        = PH_IDLE;
        last_outcome_next = ST_FAILED;
      end else begin
        phase_next          = PH_GAP;
        period_counter_next = gap_len;
        fault_seen_next     = 1'b0;
      end
    end
  end

  // result for this request
  always_comb begin
    result.line_drive    = (phase_next == PH_DRIVE);
    result.attempts_used = attempt_count_next;
    case (phase_next)
      PH_IDLE:    result.status = last_outcome_next;
      PH_BACKOFF: result.status = ST_BACKOFF;
      default:    result.status = ST_SENDING;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/dibit_pulse_bus_transmitter_unit.sv
// top level: request register, config registers, sequencer and result register
// an accepted request is held in the request register, then its result in the result register
// throughput: one request per cycle while the output is not stalled, every command, set by the single-pass sequencer
// the result register holds while stalled and the request register fills behind it
// synchronous reset returns config to defaults, the sequencer to idle and both
// registers to empty; the frame store holds no reset value
`timescale 1ns / 1ps
`default_nettype none
module dibit_pulse_bus_transmitter_unit #(
  parameter int MAX_FRAME_BYTES = dpbt_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] command,
  input  wire logic [2:0] byte_index,
  input  wire logic [7:0] byte_value,
  input  wire logic       rx_released,
  input  wire logic [5:0] backoff_random,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            line_drive,
  output logic [2:0]      status,
  output logic [3:0]      attempts_used,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  import dpbt_pkg::*;

  logic                 req_valid;
  item_t                req;
  logic                 advance, fire;
  cfg_t                 cfg;
  result_t              result, res_q;
  store_wr_t            store_wr;
  logic [POS_W-1:0]     rd_pos;
  logic [7:0]           rd_data;

  assign advance   = !out_valid || !out_stall;
  assign fire      = req_valid && advance;
  assign in_stall  = req_valid && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req.command        <= command;
      req.byte_index     <= byte_index;
      req.byte_value     <= byte_value;
      req.rx_released    <= rx_released;
      req.backoff_random <= backoff_random;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_length  <= FRAME_LENGTH_RST;
      cfg.max_attempts  <= MAX_ATTEMPTS_RST;
      cfg.idle_gap_bits <= IDLE_GAP_RST;
      cfg.backoff_base  <= BACKOFF_BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_LENGTH: cfg.frame_length  <= cfg_data[3:0];
        REG_MAX_ATTEMPTS: cfg.max_attempts  <= cfg_data[3:0];
        REG_IDLE_GAP:     cfg.idle_gap_bits <= cfg_data;
        REG_BACKOFF_BASE: cfg.backoff_base  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dpbt_frame_store #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_store (
    .clk     (clk),
    .wr      (store_wr),
    .rd_pos  (rd_pos),
    .rd_data (rd_data)
  );

  dpbt_ctrl #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (req),
    .cfg      (cfg),
    .rd_data  (rd_data),
    .store_wr (store_wr),
    .rd_pos   (rd_pos),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= result;
    end
  end

  assign line_drive    = res_q.line_drive;
  assign status        = res_q.status;
  assign attempts_used = res_q.attempts_used;

endmodule
`default_nettype wire
